>>> rtl/sdac_pkg.sv
// ----------------------------------------------------------------------------
// sdac_pkg
// Shared constants for the signed-to-decimal ASCII converter: character
// width, ASCII codes and the number of magnitude bits handled per stage.
// ----------------------------------------------------------------------------
`default_nettype none

package sdac_pkg;

	// width of one output character code
	localparam int CHAR_W = 6;

	// ASCII codes, truncated to the character width
	localparam logic [CHAR_W-1:0] CHR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHR_NINE  = 6'd57;

	// magnitude bits shifted into the BCD register by each pipeline stage
	localparam int BITS_PER_STAGE = 8;

endpackage

`default_nettype wire

>>> rtl/signed_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_to_decimal_ascii_unit
// Converts a signed two's complement value to decimal ASCII text, one
// character per cycle, most significant digit first, minus sign in front.
// ----------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  -------   -------------------------  ------------------------------------
//  request   value                      taken when start = 1 and busy = 0
//  result    character, last            shown for one cycle while strobe = 1
//
//  A request passes one input register and ceil(VALUE_WIDTH/8) double-dabble
//  stages (8 shift/add-3 steps each), then loads the character serializer.
//  Each value gives 1 to DIGITS+1 characters at one per cycle; the serializer
//  sets the sustained rate (up to 20 characters per value at VALUE_WIDTH = 64).
//  The pipeline holds further requests while the serializer drains; busy
//  rises only when the input stage cannot move. No clearing pass after reset.
//
`default_nettype none

module signed_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [VALUE_WIDTH-1:0]        value,
	output logic                               strobe,
	output logic [sdac_pkg::CHAR_W-1:0]        character,
	output logic                               last
);

	localparam int BPS    = sdac_pkg::BITS_PER_STAGE;
	localparam int NSTG   = (VALUE_WIDTH + BPS - 1) / BPS;
	localparam int MW     = NSTG * BPS;
	localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int DW     = DIGITS * 4;
	localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// one double-dabble step: adjust digits of 5 or more, shift in one bit
	function automatic logic [DW-1:0] dabble(input logic [DW-1:0] b, input logic bit_in);
		logic [DW-1:0] t;
		t = b;
		for (int d = 0; d < DIGITS; d++) begin
			if (t[d*4 +: 4] >= 4'd5) begin
				t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
			end
		end
		return {t[DW-2:0], bit_in};
	endfunction

	// pipeline registers
	logic [NSTG:0]    valid_s;
	logic [MW-1:0]    mag_s [0:NSTG-1];
	logic             neg_s [0:NSTG];
	logic [DW-1:0]    bcd_s [1:NSTG];
	logic [DW-1:0]    bcd_nxt [0:NSTG-1];

	// flow control
	logic [NSTG+1:0]  free_c;
	logic [NSTG:0]    leave_c;
	logic             accept;
	logic             ser_free;

	// serializer registers
	logic             active_q;
	logic             sign_q;
	logic [DW-1:0]    dig_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] top_c;
	logic             strobe_q;
	logic             last_q;
	logic [sdac_pkg::CHAR_W-1:0] char_q;

	// input magnitude and sign
	logic             neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;

	assign neg_in = value[VALUE_WIDTH-1];
	assign mag_in = neg_in ? (~value + VALUE_WIDTH'(1)) : value;

	// serializer can take a new value when idle or on its final digit
	assign ser_free = !active_q || (!sign_q && (idx_q == '0));

	// stage advance chain, from the serializer back to the input
	always_comb begin
		free_c[NSTG+1] = ser_free;
		for (int k = NSTG; k >= 0; k--) begin
			leave_c[k] = valid_s[k] && free_c[k+1];
			free_c[k]  = !valid_s[k] || leave_c[k];
		end
	end

	assign busy   = !free_c[0];
	assign accept = start && !busy;

	// double-dabble stages, eight magnitude bits each, MSB first
	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		always_comb begin
			logic [DW-1:0] t;
			if (k == 0) begin
				t = '0;
			end else begin
				t = bcd_s[(k == 0) ? 1 : k];
			end
			for (int b = 0; b < BPS; b++) begin
				t = dabble(t, mag_s[k][MW-1-k*BPS-b]);
			end
			bcd_nxt[k] = t;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s[0] <= accept || (valid_s[0] && !leave_c[0]);
			for (int k = 1; k <= NSTG; k++) begin
				valid_s[k] <= leave_c[k-1] || (valid_s[k] && !leave_c[k]);
			end
		end
	end

	// pipeline payload; the magnitude is not needed past the last stage
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s[0] <= MW'(mag_in);
			neg_s[0] <= neg_in;
		end
		for (int k = 0; k < NSTG - 1; k++) begin
			if (leave_c[k]) begin
				mag_s[k+1] <= mag_s[k];
			end
		end
		for (int k = 0; k < NSTG; k++) begin
			if (leave_c[k]) begin
				neg_s[k+1] <= neg_s[k];
				bcd_s[k+1] <= bcd_nxt[k];
			end
		end
	end

	// highest nonzero digit of the finished BCD word
	always_comb begin
		top_c = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_s[NSTG][i*4 +: 4] != 4'd0) begin
				top_c = IDX_W'(i);
			end
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q == '0) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			if (leave_c[NSTG]) begin
				active_q <= 1'b1;
				sign_q   <= neg_s[NSTG];
				idx_q    <= top_c;
			end
		end
	end

	// serializer payload and output character
	always_ff @(posedge clk) begin
		if (active_q) begin
			if (sign_q) begin
				char_q <= sdac_pkg::CHR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sdac_pkg::CHR_ZERO + {2'b00, dig_q[idx_q*4 +: 4]};
				last_q <= (idx_q == '0);
			end
		end
		if (leave_c[NSTG]) begin
			dig_q <= bcd_s[NSTG];
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> rtl/sdac_checker.sv
// ----------------------------------------------------------------------------
// sdac_checker
// Port-level checks on the character stream of the converter, attached to
// the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sdac_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        strobe,
	input wire logic [sdac_pkg::CHAR_W-1:0] character,
	input wire logic                        last
);

	// every character is a minus sign or a decimal digit
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == sdac_pkg::CHR_MINUS) ||
			((character >= sdac_pkg::CHR_ZERO) && (character <= sdac_pkg::CHR_NINE)))
		else $error("character code out of range");

	// the text of one value leaves without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside one value's text");

	// a minus sign never ends a value
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (character == sdac_pkg::CHR_MINUS) |-> !last)
		else $error("minus sign marked last");

	// after a minus sign comes a leading digit that is not zero
	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (character == sdac_pkg::CHR_MINUS) |=>
			strobe && (character != sdac_pkg::CHR_ZERO) &&
			(character != sdac_pkg::CHR_MINUS))
		else $error("bad character after minus sign");

endmodule

bind signed_to_decimal_ascii_unit sdac_checker u_sdac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.strobe    (strobe),
	.character (character),
	.last      (last)
);

`default_nettype wire
